### rtl/kcmr_pkg.sv
// Package: shared types and constants for the key chord macro recorder.
package kcmr_pkg;

    localparam logic [9:0] K_LCTRL  = 10'd29;
    localparam logic [9:0] K_LSHIFT = 10'd42;
    localparam logic [9:0] K_LALT   = 10'd56;

    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PLAY
    } t_state;

    // digit key bound to a slot: slot 0 is key 0 (code 11), others slot+1
    function automatic logic [9:0] digit_key(input logic [3:0] slot);
        logic [9:0] d;
        d = (slot == 4'd0) ? 10'd11 : {6'd0, slot} + 10'd1;
        return d;
    endfunction

endpackage

### rtl/kcmr_mem.sv
// Event memory: one synchronous write port, one registered read port.
module kcmr_mem #(
    parameter int DEPTH = 320,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [11:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [11:0]   o_rdata
);
    logic [11:0] r_mem [DEPTH];
    logic [11:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/key_chord_macro_recorder.sv
// Top level: key chord macro recorder with stored-event replay.
// Each input transaction is one key event. An event that does not trigger a
// replay is accepted without stalling the input. A replay reads the slot's
// stored events from an event memory with a registered read port. Each event
// passes through a read state and then a play state, and leaves as one output
// transaction. A replay of n events, at most MACRO_DEPTH, keeps the input
// stalled until its last event has been played, and longer while the output
// is stalled. Held keys, flags and per-slot lengths live in flip-flops; the
// events themselves live in a SLOTS*MACRO_DEPTH memory that needs no clearing
// since only written entries are ever read back.
module key_chord_macro_recorder #(
    parameter int SLOTS       = 10,
    parameter int MACRO_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [9:0] i_key_code,
    input  logic [1:0] i_key_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [9:0] o_replay_code,
    output logic [1:0] o_replay_value,
    output logic       o_sync_after,
    output logic       o_last_of_run
);
    localparam int LW = $clog2(MACRO_DEPTH + 1);
    localparam int SW = 4;
    localparam int MD = SLOTS * MACRO_DEPTH;
    localparam int AW = $clog2(MD);
    localparam int CW = LW + 1;

    // held-key tracker
    logic        r_hv [3];
    logic [9:0]  r_hk [3];
    logic        r_arm, r_rec;
    logic [SW-1:0] r_rslot, r_pslot;
    logic        r_pend;
    logic [SLOTS-1:0] r_def;
    logic [LW-1:0] r_len [SLOTS];

    kcmr_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_cnt, r_n;
    logic [SW-1:0]    r_ps;
    logic signed [CW-1:0] r_acc;
    logic             r_ovalid;
    logic [9:0]       r_ocode;
    logic [1:0]       r_oval;
    logic             r_osync, r_olast;

    logic acc_in;
    assign acc_in = i_valid && !o_stall;
    assign o_stall = (r_state != kcmr_pkg::ST_IDLE);

    // next held set after this event
    logic       hv_n [3];
    logic [9:0] hk_n [3];
    always_comb begin
        logic done;
        for (int k = 0; k < 3; k++) begin
            hv_n[k] = r_hv[k];
            hk_n[k] = r_hk[k];
        end
        done = 1'b0;
        if (i_key_value == kcmr_pkg::VAL_PRESS) begin
            for (int k = 0; k < 3; k++) begin
                if (!done && !r_hv[k]) begin
                    hv_n[k] = 1'b1;
                    hk_n[k] = i_key_code;
                    done = 1'b1;
                end
            end
        end else if (i_key_value == kcmr_pkg::VAL_RELEASE) begin
            for (int k = 0; k < 3; k++) begin
                if (!done && r_hv[k] && r_hk[k] == i_key_code) begin
                    hv_n[k] = 1'b0;
                    done = 1'b1;
                end
            end
        end
    end

    // chord classification
    logic           empty_c, rec_c, slot_hit;
    logic [SW-1:0]  hit_slot;
    always_comb begin
        logic [1:0] h;
        logic [9:0] d;
        empty_c = !hv_n[0] && !hv_n[1] && !hv_n[2];
        h = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if (hv_n[k] && (hk_n[k] == kcmr_pkg::K_LCTRL || hk_n[k] == kcmr_pkg::K_LALT
                            || hk_n[k] == kcmr_pkg::K_LSHIFT)) begin
                h = h + 2'd1;
            end
        end
        rec_c = !empty_c && (h == 2'd3);
        slot_hit = 1'b0;
        hit_slot = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            d = kcmr_pkg::digit_key(SW'(s));
            h = 2'd0;
            for (int k = 0; k < 3; k++) begin
                if (hv_n[k] && (hk_n[k] == kcmr_pkg::K_LCTRL
                                || hk_n[k] == kcmr_pkg::K_LSHIFT || hk_n[k] == d)) begin
                    h = h + 2'd1;
                end
            end
            if (r_def[s] && h == 2'd3) begin
                slot_hit = 1'b1;
                hit_slot = SW'(s);
            end
        end
        if (empty_c || rec_c) begin
            slot_hit = 1'b0;
        end
    end

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [11:0]   mem_rd;
    logic [LW-1:0] cur_len;
    logic [LW-1:0] rd_idx;
    assign cur_len = r_len[r_rslot];

    logic stop_ev, start_ev, store_ev, play_ev, cont;
    assign stop_ev  = rec_c && r_rec;
    assign start_ev = !rec_c && r_arm && empty_c;
    assign cont     = !stop_ev && !start_ev;
    assign store_ev = cont && r_rec && (cur_len < LW'(MACRO_DEPTH));
    assign play_ev  = cont && (r_pend || slot_hit) && empty_c;

    // hold the read address of the event on show while the output is stalled
    assign rd_idx = (r_state == kcmr_pkg::ST_PLAY) ? r_cnt - LW'(1) : r_cnt;

    assign mem_we = acc_in && store_ev;
    assign mem_wa = AW'(r_rslot * MACRO_DEPTH) + AW'(cur_len);
    assign mem_ra = AW'(r_ps * MACRO_DEPTH) + AW'(rd_idx);

    kcmr_mem #(.DEPTH(MD), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata ({i_key_value, i_key_code}),
        .i_raddr (mem_ra),
        .o_rdata (mem_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_hv[k] <= 1'b0;
            end
            r_arm   <= 1'b0;
            r_rec   <= 1'b0;
            r_rslot <= '0;
            r_pend  <= 1'b0;
            r_pslot <= '0;
            r_def   <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_len[s] <= '0;
            end
        end else if (acc_in) begin
            for (int k = 0; k < 3; k++) begin
                r_hv[k] <= hv_n[k];
                r_hk[k] <= hk_n[k];
            end
            if (stop_ev) begin
                r_arm <= 1'b0;
                r_rec <= 1'b0;
                r_len[r_rslot] <= (cur_len >= LW'(2)) ? cur_len - LW'(2) : '0;
                r_def[r_rslot] <= 1'b1;
                r_rslot <= (r_rslot == SW'(SLOTS - 1)) ? '0 : r_rslot + SW'(1);
            end else if (start_ev) begin
                r_arm <= 1'b0;
                r_rec <= 1'b1;
                r_len[r_rslot] <= '0;
            end else begin
                if (rec_c) begin
                    r_arm <= 1'b1;
                end
                if (store_ev) begin
                    r_len[r_rslot] <= cur_len + LW'(1);
                end
                if (slot_hit) begin
                    r_pend  <= 1'b1;
                    r_pslot <= hit_slot;
                end
                if (play_ev) begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    // replay sequencer
    logic [SW-1:0] play_slot;
    logic [LW-1:0] play_len;
    assign play_slot = slot_hit ? hit_slot : r_pslot;
    assign play_len  = (store_ev && play_slot == r_rslot) ? cur_len + LW'(1)
                                                          : r_len[play_slot];

    logic o_free;
    assign o_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            kcmr_pkg::ST_IDLE: begin
                if (acc_in && play_ev && play_len != '0) begin
                    n_state = kcmr_pkg::ST_READ;
                end
            end
            kcmr_pkg::ST_READ: begin
                n_state = kcmr_pkg::ST_PLAY;
            end
            kcmr_pkg::ST_PLAY: begin
                if (o_free) begin
                    n_state = (r_cnt == r_n) ? kcmr_pkg::ST_IDLE : kcmr_pkg::ST_READ;
                end
            end
            default: n_state = kcmr_pkg::ST_IDLE;
        endcase
    end

    logic signed [CW-1:0] acc_nx;
    assign acc_nx = (mem_rd[11:10] != kcmr_pkg::VAL_RELEASE) ? r_acc + CW'(1)
                                                              : r_acc - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kcmr_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == kcmr_pkg::ST_PLAY && o_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                kcmr_pkg::ST_IDLE: begin
                    r_ps  <= play_slot;
                    r_n   <= play_len;
                    r_cnt <= '0;
                    r_acc <= '0;
                end
                kcmr_pkg::ST_READ: begin
                    r_cnt <= r_cnt + LW'(1);
                end
                kcmr_pkg::ST_PLAY: begin
                    if (o_free) begin
                        r_ocode  <= mem_rd[9:0];
                        r_oval   <= mem_rd[11:10];
                        r_osync  <= (acc_nx == '0);
                        r_olast  <= (r_cnt == r_n);
                        r_acc    <= acc_nx;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_replay_code  = r_ocode;
    assign o_replay_value = r_oval;
    assign o_sync_after   = r_osync;
    assign o_last_of_run  = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kcmr_pkg::ST_IDLE) |-> o_stall)
        else $error("input accepted during replay");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kcmr_pkg::ST_PLAY) |-> (r_cnt <= r_n && r_cnt != '0))
        else $error("replay index out of range");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[r_rslot] <= LW'(MACRO_DEPTH))
        else $error("slot length past depth");
`endif
endmodule
